// ----- src/xeu_pkg.sv -----
package xeu_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // Match states: which entity prefix is currently held.
    typedef enum logic [3:0] {
        PFX_IDLE = 4'd0,
        PFX_AMP  = 4'd1,
        PFX_A    = 4'd2,
        PFX_AM   = 4'd3,
        PFX_AMP4 = 4'd4,
        PFX_AP   = 4'd5,
        PFX_APO  = 4'd6,
        PFX_APOS = 4'd7,
        PFX_L    = 4'd8,
        PFX_LT   = 4'd9,
        PFX_G    = 4'd10,
        PFX_GT   = 4'd11,
        PFX_Q    = 4'd12,
        PFX_QU   = 4'd13,
        PFX_QUO  = 4'd14,
        PFX_QUOT = 4'd15
    } pfx_t;

    typedef enum logic [1:0] {
        ADV_NONE,
        ADV_LONGER,
        ADV_DONE
    } adv_kind_t;

    typedef struct packed {
        adv_kind_t  kind;
        pfx_t       nxt;
        logic [7:0] dec;
    } adv_t;

    // One job: held bytes to flush, an optional middle byte, held bytes flushed at end of text.
    typedef struct packed {
        pfx_t       flush_pre;
        logic       mid_vld;
        logic [7:0] mid_byte;
        pfx_t       flush_post;
        logic       text_end;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

    typedef struct packed {
        logic not_empty;
        job_t job;
    } job_head_t;

    function automatic logic [2:0] prefix_len(input pfx_t code);
        logic [2:0] len;
        unique case (code)
            PFX_IDLE:                         len = 3'd0;
            PFX_AMP:                          len = 3'd1;
            PFX_A, PFX_L, PFX_G, PFX_Q:       len = 3'd2;
            PFX_AM, PFX_AP, PFX_LT, PFX_GT,
            PFX_QU:                           len = 3'd3;
            PFX_AMP4, PFX_APO, PFX_QUO:       len = 3'd4;
            PFX_APOS, PFX_QUOT:               len = 3'd5;
            default:                          len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] prefix_char(input pfx_t code, input logic [2:0] idx);
        logic [7:0] ch;
        ch = CH_AMP;
        unique case (idx)
            3'd0: ch = CH_AMP;
            3'd1:
                unique case (code) inside
                    [PFX_A:PFX_APOS]: ch = CH_A;
                    PFX_L, PFX_LT:    ch = CH_L;
                    PFX_G, PFX_GT:    ch = CH_G;
                    default:          ch = CH_Q;
                endcase
            3'd2:
                unique case (code) inside
                    PFX_AM, PFX_AMP4:          ch = CH_M;
                    PFX_AP, PFX_APO, PFX_APOS: ch = CH_P;
                    PFX_LT, PFX_GT:            ch = CH_T;
                    default:                   ch = CH_U;
                endcase
            3'd3:
                unique case (code)
                    PFX_AMP4: ch = CH_P;
                    default:  ch = CH_O;
                endcase
            3'd4:
                unique case (code)
                    PFX_APOS: ch = CH_S;
                    default:  ch = CH_T;
                endcase
            default: ch = CH_AMP;
        endcase
        return ch;
    endfunction

    function automatic adv_t advance(input pfx_t st, input logic [7:0] c);
        adv_t r;
        r.kind = ADV_NONE;
        r.nxt  = PFX_IDLE;
        r.dec  = CH_AMP;
        unique case (st)
            PFX_IDLE:
                if (c == CH_AMP) begin r.kind = ADV_LONGER; r.nxt = PFX_AMP; end
            PFX_AMP:
                if (c == CH_A) begin r.kind = ADV_LONGER; r.nxt = PFX_A; end
                else if (c == CH_L) begin r.kind = ADV_LONGER; r.nxt = PFX_L; end
                else if (c == CH_G) begin r.kind = ADV_LONGER; r.nxt = PFX_G; end
                else if (c == CH_Q) begin r.kind = ADV_LONGER; r.nxt = PFX_Q; end
            PFX_A:
                if (c == CH_M) begin r.kind = ADV_LONGER; r.nxt = PFX_AM; end
                else if (c == CH_P) begin r.kind = ADV_LONGER; r.nxt = PFX_AP; end
            PFX_AM:
                if (c == CH_P) begin r.kind = ADV_LONGER; r.nxt = PFX_AMP4; end
            PFX_AMP4:
                if (c == CH_SEMI) begin r.kind = ADV_DONE; r.dec = CH_AMP; end
            PFX_AP:
                if (c == CH_O) begin r.kind = ADV_LONGER; r.nxt = PFX_APO; end
            PFX_APO:
                if (c == CH_S) begin r.kind = ADV_LONGER; r.nxt = PFX_APOS; end
            PFX_APOS:
                if (c == CH_SEMI) begin r.kind = ADV_DONE; r.dec = CH_APOS; end
            PFX_L:
                if (c == CH_T) begin r.kind = ADV_LONGER; r.nxt = PFX_LT; end
            PFX_LT:
                if (c == CH_SEMI) begin r.kind = ADV_DONE; r.dec = CH_LT; end
            PFX_G:
                if (c == CH_T) begin r.kind = ADV_LONGER; r.nxt = PFX_GT; end
            PFX_GT:
                if (c == CH_SEMI) begin r.kind = ADV_DONE; r.dec = CH_GT; end
            PFX_Q:
                if (c == CH_U) begin r.kind = ADV_LONGER; r.nxt = PFX_QU; end
            PFX_QU:
                if (c == CH_O) begin r.kind = ADV_LONGER; r.nxt = PFX_QUO; end
            PFX_QUO:
                if (c == CH_T) begin r.kind = ADV_LONGER; r.nxt = PFX_QUOT; end
            PFX_QUOT:
                if (c == CH_SEMI) begin r.kind = ADV_DONE; r.dec = CH_QUOT; end
            default: r.kind = ADV_NONE;
        endcase
        return r;
    endfunction

endpackage

// ----- src/xeu_in_if.sv -----
interface xeu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_end;

    modport source (output valid, output in_byte, output text_end, input ready);
    modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

// ----- src/xeu_out_if.sv -----
interface xeu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_last;

    modport source (output valid, output out_byte, output run_last, output stream_last,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input stream_last,
                  output ready);
endinterface

// ----- src/xeu_front.sv -----
module xeu_front (
    input  logic               clk,
    input  logic               rst_n,
    xeu_in_if.sink             in_ch,
    input  logic               queue_full,
    output xeu_pkg::job_push_t push
);
    import xeu_pkg::*;

    pfx_t match_reg;
    pfx_t match_next;
    logic accept;

    assign in_ch.ready = !queue_full;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        adv_t r;
        pfx_t st;
        r          = advance(match_reg, in_ch.in_byte);
        st         = match_reg;
        push.job   = '0;
        push.job.flush_pre = PFX_IDLE;
        push.job.flush_post = PFX_IDLE;

        // A broken match flushes what is held, then the byte is tried from idle.
        if (r.kind == ADV_NONE && match_reg != PFX_IDLE) begin
            push.job.flush_pre = match_reg;
            r = advance(PFX_IDLE, in_ch.in_byte);
        end

        unique case (r.kind)
            ADV_LONGER: st = r.nxt;
            ADV_DONE:
            begin
                push.job.mid_vld  = 1'b1;
                push.job.mid_byte = r.dec;
                st                = PFX_IDLE;
            end
            default:
            begin
                push.job.mid_vld  = 1'b1;
                push.job.mid_byte = in_ch.in_byte;
                st                = PFX_IDLE;
            end
        endcase

        push.job.text_end = in_ch.text_end;
        if (in_ch.text_end) begin
            push.job.flush_post = st;
            st = PFX_IDLE;
        end

        match_next = accept ? st : match_reg;
        push.valid = accept && (push.job.flush_pre != PFX_IDLE || push.job.mid_vld ||
                                push.job.flush_post != PFX_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            match_reg <= PFX_IDLE;
        end else begin
            match_reg <= match_next;
        end
    end

endmodule

// ----- src/xeu_queue.sv -----
module xeu_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  xeu_pkg::job_push_t push,
    input  logic               pop,
    output logic               full,
    output xeu_pkg::job_head_t head
);
    import xeu_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full           = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head.not_empty = (count_reg != '0);
    assign head.job       = slots_reg[rd_ptr_reg];
    assign do_push        = push.valid && !full;
    assign do_pop         = pop && head.not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

// ----- src/xeu_back.sv -----
module xeu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  xeu_pkg::job_head_t head,
    output logic               pop,
    xeu_out_if.source          out_ch
);
    import xeu_pkg::*;

    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;
    logic       stream_last_reg;
    logic       load;
    logic [3:0] len_pre;
    logic [3:0] len_post;
    logic [3:0] mid_cnt;
    logic [3:0] total;
    logic [3:0] pos4;
    logic [3:0] post_idx;
    logic [7:0] cur_byte;
    logic       cur_last;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.run_last    = run_last_reg;
    assign out_ch.stream_last = stream_last_reg;

    // The output register is free when empty or when its beat leaves this cycle.
    assign load = head.not_empty && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        len_pre  = {1'b0, prefix_len(head.job.flush_pre)};
        len_post = {1'b0, prefix_len(head.job.flush_post)};
        mid_cnt  = {3'b000, head.job.mid_vld};
        total    = len_pre + mid_cnt + len_post;
        pos4     = {1'b0, pos_reg};
        post_idx = pos4 - len_pre - mid_cnt;
        if (pos4 < len_pre) begin
            cur_byte = prefix_char(head.job.flush_pre, pos_reg);
        end else if (head.job.mid_vld && pos4 == len_pre) begin
            cur_byte = head.job.mid_byte;
        end else begin
            cur_byte = prefix_char(head.job.flush_post, post_idx[2:0]);
        end
        cur_last = (pos4 == total - 4'd1);

        pop      = load && cur_last;
        pos_next = pos_reg;
        if (load) begin
            pos_next = cur_last ? '0 : pos_reg + 3'd1;
        end

        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ch.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_byte_reg    <= cur_byte;
            run_last_reg    <= cur_last;
            stream_last_reg <= cur_last && head.job.text_end;
        end
    end

endmodule

// ----- src/xml_entity_unescape_top.sv -----
// Channel   Dir  Beat payload                         Accepted when
// in_ch     in   in_byte[7:0], text_end               valid && ready
// out_ch    out  out_byte[7:0], run_last, stream_last valid && ready
//
// An input beat is classified in the cycle it is accepted; one input per cycle is taken
// while the two-entry job queue has room.
// The back end sends one output beat per cycle while out_ch is ready, so an item that
// yields k bytes (up to 6) becomes k beats and an item that is only held gives the back
// end no job; a flush of a broken or unfinished entity is the long case.
// Reset leaves the decoder idle with nothing held and both queue and output empty.
// A stalled output holds its beat; input keeps flowing until the queue fills.
module xml_entity_unescape_top (
    input  logic      clk,
    input  logic      rst_n,
    xeu_in_if.sink    in_ch,
    xeu_out_if.source out_ch
);
    import xeu_pkg::*;

    job_push_t push;
    job_head_t head;
    logic      queue_full;
    logic      pop;

    xeu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .queue_full (queue_full),
        .push       (push)
    );

    xeu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    xeu_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import xeu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TOTAL_ITEMS = 350;
    localparam int CALM_FROM   = 300;
    localparam int PAUSE_AT    = 200;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       stream_last;
    } text_beat_t;

    // Tracks the held entity prefix and the decoded bytes still owed by the block.
    class unescape_predictor;
        string      held_text[16];
        string      ent_text[5];
        logic [7:0] ent_char[5];
        pfx_t       held;
        text_beat_t due[$];
        int         errors;

        function new();
            held_text = '{"", "&", "&a", "&am", "&amp", "&ap", "&apo", "&apos",
                          "&l", "&lt", "&g", "&gt", "&q", "&qu", "&quo", "&quot"};
            ent_text  = '{"&amp;", "&lt;", "&gt;", "&quot;", "&apos;"};
            ent_char  = '{CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS};
            held      = PFX_IDLE;
            errors    = 0;
        endfunction

        // True when the prefix held in st followed by c spells s exactly.
        function bit spells(string s, pfx_t st, logic [7:0] c);
            string h;
            h = held_text[st];
            if (s.len() != h.len() + 1)
                return 1'b0;
            for (int i = 0; i < h.len(); i++)
                if (s.getc(i) != h.getc(i))
                    return 1'b0;
            return s.getc(h.len()) == c;
        endfunction

        function adv_kind_t extend(pfx_t st, logic [7:0] c, output pfx_t nxt,
                                   output logic [7:0] dec);
            nxt = PFX_IDLE;
            dec = 8'h00;
            for (int k = 0; k < 5; k++)
                if (spells(ent_text[k], st, c))
                begin
                    dec = ent_char[k];
                    return ADV_DONE;
                end
            for (int k = 1; k < 16; k++)
                if (spells(held_text[k], st, c))
                begin
                    nxt = pfx_t'(k);
                    return ADV_LONGER;
                end
            return ADV_NONE;
        endfunction

        function void spill(pfx_t st, ref logic [7:0] q[$]);
            for (int i = 0; i < held_text[st].len(); i++)
                q.push_back(held_text[st].getc(i));
        endfunction

        function void take_input(logic [7:0] c, logic eot);
            logic [7:0] outq[$];
            pfx_t       st;
            pfx_t       nxt;
            logic [7:0] dec;
            adv_kind_t  kind;
            text_beat_t b;
            st = held;
            kind = extend(st, c, nxt, dec);
            // A broken match releases the held bytes, then the byte starts over from idle.
            if (kind == ADV_NONE && st != PFX_IDLE)
            begin
                spill(st, outq);
                st = PFX_IDLE;
                kind = extend(st, c, nxt, dec);
            end
            case (kind)
                ADV_NONE:
                begin
                    outq.push_back(c);
                    st = PFX_IDLE;
                end
                ADV_LONGER:
                    st = nxt;
                default:
                begin
                    outq.push_back(dec);
                    st = PFX_IDLE;
                end
            endcase
            if (eot)
            begin
                spill(st, outq);
                st = PFX_IDLE;
            end
            held = st;
            foreach (outq[i])
            begin
                b.data        = outq[i];
                b.run_last    = (i == outq.size() - 1);
                b.stream_last = (i == outq.size() - 1) && eot;
                due.push_back(b);
            end
        endfunction

        function void match_output(text_beat_t got);
            text_beat_t want;
            if (due.size() == 0)
            begin
                $display("%0t: beat with no expectation, expected none, actual %02h/%0b/%0b",
                         $time, got.data, got.run_last, got.stream_last);
                errors++;
                return;
            end
            want = due.pop_front();
            if (got.data !== want.data)
            begin
                $display("%0t: out_byte expected %02h, actual %02h", $time, want.data, got.data);
                errors++;
            end
            if (got.run_last !== want.run_last)
            begin
                $display("%0t: run_last expected %0b, actual %0b",
                         $time, want.run_last, got.run_last);
                errors++;
            end
            if (got.stream_last !== want.stream_last)
            begin
                $display("%0t: stream_last expected %0b, actual %0b",
                         $time, want.stream_last, got.stream_last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   fed;
    int   cycles;

    unescape_predictor board;

    xeu_in_if  in_ch();
    xeu_out_if out_ch();

    xml_entity_unescape_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("xml_entity_unescape_top verification failed");
            $finish;
        end
    end

    // Inputs are noted before outputs are checked, so a same-edge result always finds its entry.
    always @(posedge clk)
    begin
        text_beat_t seen;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                board.take_input(in_ch.in_byte, in_ch.text_end);
            if (out_ch.valid && out_ch.ready)
            begin
                seen.data        = out_ch.out_byte;
                seen.run_last    = out_ch.run_last;
                seen.stream_last = out_ch.stream_last;
                board.match_output(seen);
            end
        end
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [7:0] c, input logic eot);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.in_byte  <= c;
        in_ch.text_end <= eot;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        fed++;
    endtask

    task automatic send_text(input string s, input bit end_last);
        for (int i = 0; i < s.len(); i++)
            push_byte(s.getc(i), end_last && (i == s.len() - 1));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        string      piece;
        string      ent;
        string      letters;
        int         mode;
        int         cut;
        int         n;
        bit         ended;
        bit         paused;
        logic [7:0] c;

        board   = new();
        letters = "&amplgtquos;";
        paused  = 1'b0;
        fed     = 0;
        cycles  = 0;
        idle_on = 1'b1;
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.in_byte  <= 8'h00;
        in_ch.text_end <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single pass: the decoded ampersand must not start a new match.
        send_text("&amp;lt;", 1'b0);
        // An ampersand breaks the held "&gt" and starts the next entity.
        send_text("&gt&quot;", 1'b0);
        send_text("&apos", 1'b0);
        push_byte(8'hFF, 1'b0);
        send_text("&lt;", 1'b1);
        // End of text with a prefix still held.
        send_text("&am", 1'b1);
        push_byte(8'h00, 1'b0);
        drain();

        while (fed < TOTAL_ITEMS)
        begin
            if (fed >= CALM_FROM)
                idle_on = 1'b0;
            if (!paused && fed >= PAUSE_AT)
            begin
                drain();
                paused = 1'b1;
            end
            mode = $urandom_range(0, 9);
            ent  = board.ent_text[$urandom_range(0, 4)];
            if (mode <= 3)
                send_text(ent, $urandom_range(0, 7) == 0);
            else if (mode <= 5)
            begin
                cut   = $urandom_range(1, ent.len() - 1);
                piece = ent.substr(0, cut - 1);
                ended = ($urandom_range(0, 5) == 0);
                send_text(piece, ended);
                if (!ended)
                begin
                    if ($urandom_range(0, 3) == 0)
                        c = CH_AMP;
                    else
                        c = 8'($urandom_range(0, 255));
                    push_byte(c, $urandom_range(0, 7) == 0);
                end
            end
            else if (mode <= 8)
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    push_byte(8'($urandom_range(0, 255)),
                              (i == n - 1) && ($urandom_range(0, 7) == 0));
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    push_byte(letters.getc($urandom_range(0, letters.len() - 1)),
                              $urandom_range(0, 9) == 0);
            end
        end

        drain();
        repeat (30) @(posedge clk);
        if (board.errors == 0 && board.due.size() == 0)
            $display("xml_entity_unescape_top verification clean");
        else
            $display("xml_entity_unescape_top verification failed");
        $finish;
    end
endmodule
